// ----- hdl/smm_pkg.sv -----
`timescale 1ns / 1ps

package smm_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned POS_W  = 32;
    localparam int unsigned FEAT_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 3;

    // Default feature count, and the most results one close can emit.
    localparam int unsigned FEATURES_DEF = 8;
    localparam int unsigned EMIT_LIMIT   = 8;

    // Command codes of an input transaction.
    localparam logic CMD_ELEM  = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    // Reduction kinds held in the mode register.
    localparam logic MODE_MIN = 1'b0;
    localparam logic MODE_MAX = 1'b1;

    // Register indexes (byte address is four times the index).
    localparam logic [ADDR_W-3:0] REG_MODE = 1'b0;
    localparam logic [ADDR_W-3:0] REG_FILL = 1'b1;

    // Control states.
    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } smm_state_t;

    // One stored entry of a cell.
    typedef struct packed {
        logic              seen;
        logic [VAL_W-1:0]  value;
        logic [POS_W-1:0]  position;
    } smm_entry_t;

    // Element broadcast to every cell.
    typedef struct packed {
        logic              valid;
        logic              mode;
        logic [VAL_W-1:0]  value;
        logic [FEAT_W-1:0] feature;
        logic [POS_W-1:0]  position;
    } smm_elem_t;

endpackage

// ----- hdl/segmented_min_max_with_arg.sv -----
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_ready    cmd, value, feature, position
// output    out_valid / out_ready  out_value, out_position, out_feature, last
// config    APB (psel, penable)    paddr, pwdata, prdata
//
// An element transaction is folded into its feature's cell at the accepting
// edge, so elements can follow back to back. A close transaction starts a
// drain of min(FEATURES, 8) results with input held off, one result per cycle
// unless the output stalls; the close passes through the state register and
// each result through the output register. A stalled output holds the chain
// in place. Reset clears control, seen flags and registers only.

module segmented_min_max_with_arg #(
    parameter int unsigned FEATURES = smm_pkg::FEATURES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Input channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        cmd,
    input  logic signed [smm_pkg::VAL_W-1:0]  value,
    input  logic [smm_pkg::FEAT_W-1:0]  feature,
    input  logic [smm_pkg::POS_W-1:0]   position,
    // Output channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [smm_pkg::VAL_W-1:0]  out_value,
    output logic [smm_pkg::POS_W-1:0]   out_position,
    output logic [smm_pkg::FEAT_W-1:0]  out_feature,
    output logic                        last,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [smm_pkg::ADDR_W-1:0]  paddr,
    input  logic [smm_pkg::DATA_W-1:0]  pwdata,
    output logic [smm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import smm_pkg::*;

    localparam int unsigned NCELL = (FEATURES < EMIT_LIMIT) ? FEATURES : EMIT_LIMIT;
    localparam int unsigned CNT_W = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NCELL - 1);

    smm_state_t        state_reg;
    smm_state_t        state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              mode_reg;
    logic [POS_W-1:0]  fill_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [VAL_W-1:0]  out_value_reg;
    logic [POS_W-1:0]  out_position_reg;
    logic [FEAT_W-1:0] out_feature_reg;
    logic              last_reg;

    logic              in_fire;
    logic              out_space;
    logic              shift;
    logic              cfg_write;
    smm_elem_t         elem;
    smm_entry_t        cell_q [NCELL];
    smm_entry_t        cell_from [NCELL];

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MIN;
            fill_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[ADDR_W-1:2])
                REG_MODE: mode_reg <= pwdata[0];
                REG_FILL: fill_reg <= pwdata[POS_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[ADDR_W-1:2])
            REG_MODE: prdata = {{(DATA_W-1){1'b0}}, mode_reg};
            REG_FILL: prdata = fill_reg;
            default:  prdata = '0;
        endcase
    end

    // Handshake and element broadcast.
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_space = !out_valid_reg || out_ready;
    assign shift     = (state_reg == ST_DRAIN) && out_space;

    assign elem.valid    = in_fire && (cmd == CMD_ELEM);
    assign elem.mode     = mode_reg;
    assign elem.value    = value;
    assign elem.feature  = feature;
    assign elem.position = position;

    // Row of cells; each hands its entry to its lower neighbour on a drain.
    genvar k;
    generate
        for (k = 0; k < NCELL; k++)
        begin : g_cell
            if (k == NCELL - 1)
            begin : g_end
                assign cell_from[k] = '0;
            end
            else
            begin : g_mid
                assign cell_from[k] = cell_q[k+1];
            end

            smm_cell #(
                .CELL_IDX (k)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .elem      (elem),
                .shift     (shift),
                .from_next (cell_from[k]),
                .entry     (cell_q[k])
            );
        end
    endgenerate

    // Drain sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (cmd == CMD_CLOSE))
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                if (shift)
                begin
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Output register: loaded from the head cell on every drain step.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (shift)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            out_value_reg    <= cell_q[0].seen ? cell_q[0].value : '0;
            out_position_reg <= cell_q[0].seen ? cell_q[0].position : fill_reg;
            out_feature_reg  <= FEAT_W'(cnt_reg);
            last_reg         <= (cnt_reg == CNT_LAST);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign out_position = out_position_reg;
    assign out_feature  = out_feature_reg;
    assign last         = last_reg;

endmodule

// ----- hdl/smm_cell.sv -----
`timescale 1ns / 1ps

module smm_cell #(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  smm_pkg::smm_elem_t  elem,
    input  logic              shift,
    input  smm_pkg::smm_entry_t from_next,
    output smm_pkg::smm_entry_t entry
);
    import smm_pkg::*;

    logic             seen_reg;
    logic             seen_next;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;
    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] position_next;
    logic             hit;
    logic             better;

    // An element belongs to this cell when its feature matches the cell's column.
    assign hit = elem.valid && (elem.feature == FEAT_W'(CELL_IDX));

    // Strict improvement only, so the first element seen keeps a tie.
    always_comb
    begin
        if (!seen_reg)
        begin
            better = 1'b1;
        end
        else if (elem.mode == MODE_MAX)
        begin
            better = $signed(elem.value) > $signed(value_reg);
        end
        else
        begin
            better = $signed(elem.value) < $signed(value_reg);
        end
    end

    // During a drain the entry moves one cell towards the output.
    always_comb
    begin
        seen_next     = seen_reg;
        value_next    = value_reg;
        position_next = position_reg;
        if (shift)
        begin
            seen_next     = from_next.seen;
            value_next    = from_next.value;
            position_next = from_next.position;
        end
        else if (hit && better)
        begin
            seen_next     = 1'b1;
            value_next    = elem.value;
            position_next = elem.position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        position_reg <= position_next;
    end

    assign entry.seen     = seen_reg;
    assign entry.value    = value_reg;
    assign entry.position = position_reg;

endmodule
